// ===== src/ttst_pkg.sv =====
package ttst_pkg;

	localparam int TasksDefault = 8;
	localparam int MaxResults   = 8;
	localparam int ResCntW      = $clog2(MaxResults + 1);

	localparam logic [1:0] ReqAdd      = 2'd0;
	localparam logic [1:0] ReqDelete   = 2'd1;
	localparam logic [1:0] ReqTick     = 2'd2;
	localparam logic [1:0] ReqDispatch = 2'd3;

	localparam logic [2:0] KindAdded      = 3'd0;
	localparam logic [2:0] KindFull       = 3'd1;
	localparam logic [2:0] KindDeleted    = 3'd2;
	localparam logic [2:0] KindTickFire   = 3'd3;
	localparam logic [2:0] KindTickQuiet  = 3'd4;
	localparam logic [2:0] KindDispRun    = 3'd5;
	localparam logic [2:0] KindDispIdle   = 3'd6;

	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] delay;
		logic [31:0] period;
		logic [7:0]  pending;
		logic [7:0]  runs_left;
		logic        mode;
	} slot_entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  slot;
		logic [15:0] tag;
	} result_t;

endpackage

// ===== src/tick_task_scheduler_table_top.sv =====
// channel   | handshake              | payload
// config    | run_limit_enable_we    | run_limit_enable
// request   | start high, busy low   | req_type task_slot task_tag start_delay period run_limit mode
// result    | result_valid (1 cycle) | kind task_slot_out task_tag_out last
// add passes through S_ADD and delete through S_DEL_RD then S_DEL, from start to the last result strobe
// tick and dispatch walk the table one slot per cycle through the slot memory
// read port; results come out as the walk goes, the final one at its end
// busy drops in the cycle that shows the last result of the item
// reset empties the table and sets run_limit_enable; results cannot be held off
module tick_task_scheduler_table_top #(
	parameter int TASKS = ttst_pkg::TasksDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        run_limit_enable_we,
	input  logic        run_limit_enable,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  task_slot,
	input  logic [15:0] task_tag,
	input  logic [31:0] start_delay,
	input  logic [31:0] period,
	input  logic [7:0]  run_limit,
	input  logic        mode,
	output logic        result_valid,
	output logic [2:0]  kind,
	output logic [2:0]  task_slot_out,
	output logic [15:0] task_tag_out,
	output logic        last
);

	localparam int SW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int RW = ttst_pkg::ResCntW;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADD    = 3'd1;
	localparam logic [2:0] S_DEL_RD = 3'd2;
	localparam logic [2:0] S_DEL    = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_END    = 3'd5;

	logic [2:0]  state_q;
	logic        rle_q;
	logic [TASKS-1:0] used_q;

	logic [1:0]  req_q;
	logic [2:0]  slot_q;
	logic [15:0] tag_q;
	logic [31:0] delay_q;
	logic [31:0] period_q;
	logic [7:0]  limit_q;
	logic        mode_q;

	ttst_pkg::slot_entry_t slot_mem [TASKS];
	ttst_pkg::slot_entry_t rd_q;

	logic [SW:0]   cnt_q;
	logic          p_vld_s1;
	logic [SW-1:0] p_idx_s1;

	logic              buf_vld_q;
	ttst_pkg::result_t buf_q;
	logic [RW-1:0]     res_cnt_q;

	logic        result_valid_q;
	ttst_pkg::result_t out_q;
	logic        last_q;

	logic [SW-1:0] rd_addr;
	logic [SW-1:0] del_addr;
	logic          del_in_range;
	logic          free_found;
	logic [SW-1:0] free_idx;

	ttst_pkg::slot_entry_t nxt;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	ttst_pkg::slot_entry_t wr_data;
	logic          kill;
	logic          gen;
	logic [2:0]    gen_kind;
	logic          active;
	logic [7:0]    rl_new;
	logic          budget_hit;

	assign busy          = (state_q != S_IDLE);
	assign result_valid  = result_valid_q;
	assign kind          = out_q.kind;
	assign task_slot_out = out_q.slot;
	assign task_tag_out  = out_q.tag;
	assign last          = last_q;

	assign del_addr     = SW'(slot_q);
	assign del_in_range = ({29'd0, slot_q} < 32'(TASKS));
	assign rd_addr      = (state_q == S_DEL_RD) ? del_addr : cnt_q[SW-1:0];

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TASKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// per-slot update during a walk
	always_comb begin
		nxt        = rd_q;
		kill       = 1'b0;
		gen        = 1'b0;
		gen_kind   = ttst_pkg::KindTickFire;
		active     = (state_q == S_WALK) && p_vld_s1 && used_q[p_idx_s1];
		budget_hit = rle_q && (rd_q.runs_left == 8'd1);
		rl_new     = (rle_q && (rd_q.runs_left != 8'd0)) ? (rd_q.runs_left - 8'd1)
			: rd_q.runs_left;
		if (req_q == ttst_pkg::ReqTick) begin
			if (rd_q.delay != 32'd0) begin
				nxt.delay = rd_q.delay - 32'd1;
			end else begin
				if (rd_q.mode) begin
					gen           = active;
					gen_kind      = ttst_pkg::KindTickFire;
					nxt.runs_left = rl_new;
					kill          = budget_hit || (rd_q.period == 32'd0);
				end else if (rd_q.pending != 8'hFF) begin
					nxt.pending = rd_q.pending + 8'd1;
				end
				if (!kill && (rd_q.period != 32'd0)) begin
					nxt.delay = rd_q.period;
				end
			end
		end else if (rd_q.pending != 8'd0) begin
			gen           = active;
			gen_kind      = ttst_pkg::KindDispRun;
			nxt.pending   = rd_q.pending - 8'd1;
			nxt.runs_left = rl_new;
			kill          = budget_hit || (rd_q.period == 32'd0);
		end
	end

	always_comb begin
		if (state_q == S_ADD) begin
			wr_en   = free_found;
			wr_addr = free_idx;
			wr_data = '{tag: tag_q, delay: delay_q, period: period_q, pending: 8'd0,
				runs_left: limit_q, mode: mode_q};
		end else begin
			wr_en   = active;
			wr_addr = p_idx_s1;
			wr_data = nxt;
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		rd_q <= slot_mem[rd_addr];
	end

	// request fields
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q    <= req_type;
			slot_q   <= task_slot;
			tag_q    <= task_tag;
			delay_q  <= start_delay;
			period_q <= period;
			limit_q  <= run_limit;
			mode_q   <= mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_q <= 1'b1;
		end else if (run_limit_enable_we) begin
			rle_q <= run_limit_enable;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			used_q         <= '0;
			cnt_q          <= '0;
			p_vld_s1       <= 1'b0;
			p_idx_s1       <= '0;
			buf_vld_q      <= 1'b0;
			buf_q          <= '0;
			res_cnt_q      <= '0;
			result_valid_q <= 1'b0;
			out_q          <= '0;
			last_q         <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					result_valid_q <= 1'b0;
					if (start) begin
						cnt_q     <= '0;
						p_vld_s1  <= 1'b0;
						buf_vld_q <= 1'b0;
						res_cnt_q <= '0;
						unique case (req_type)
							ttst_pkg::ReqAdd:    state_q <= S_ADD;
							ttst_pkg::ReqDelete: state_q <= S_DEL_RD;
							default:             state_q <= S_WALK;
						endcase
					end
				end
				S_ADD: begin
					result_valid_q <= 1'b1;
					last_q         <= 1'b1;
					out_q.tag      <= tag_q;
					if (free_found) begin
						used_q[free_idx] <= 1'b1;
						out_q.kind       <= ttst_pkg::KindAdded;
						out_q.slot       <= 3'(free_idx);
					end else begin
						out_q.kind <= ttst_pkg::KindFull;
						out_q.slot <= 3'd0;
					end
					state_q <= S_IDLE;
				end
				S_DEL_RD: begin
					result_valid_q <= 1'b0;
					state_q        <= S_DEL;
				end
				S_DEL: begin
					result_valid_q <= 1'b1;
					last_q         <= 1'b1;
					out_q.kind     <= ttst_pkg::KindDeleted;
					out_q.slot     <= slot_q;
					out_q.tag      <= (del_in_range && used_q[del_addr]) ? rd_q.tag : '0;
					if (del_in_range) begin
						used_q[del_addr] <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				S_WALK: begin
					p_vld_s1 <= (cnt_q < (SW + 1)'(TASKS));
					p_idx_s1 <= cnt_q[SW-1:0];
					if (cnt_q < (SW + 1)'(TASKS)) begin
						cnt_q <= cnt_q + (SW + 1)'(1);
					end else if (!p_vld_s1) begin
						state_q <= S_END;
					end
					if (active && kill) begin
						used_q[p_idx_s1] <= 1'b0;
					end
					result_valid_q <= gen && buf_vld_q
						&& (res_cnt_q < RW'(ttst_pkg::MaxResults));
					if (gen && (res_cnt_q < RW'(ttst_pkg::MaxResults))) begin
						if (buf_vld_q) begin
							last_q <= 1'b0;
							out_q  <= buf_q;
						end
						buf_vld_q  <= 1'b1;
						buf_q.kind <= gen_kind;
						buf_q.slot <= 3'(p_idx_s1);
						buf_q.tag  <= rd_q.tag;
						res_cnt_q  <= res_cnt_q + RW'(1);
					end
				end
				S_END: begin
					result_valid_q <= 1'b1;
					last_q         <= 1'b1;
					if (buf_vld_q) begin
						out_q <= buf_q;
					end else begin
						out_q.kind <= (req_q == ttst_pkg::ReqTick) ? ttst_pkg::KindTickQuiet
							: ttst_pkg::KindDispIdle;
						out_q.slot <= 3'd0;
						out_q.tag  <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					result_valid_q <= 1'b0;
					state_q        <= S_IDLE;
				end
			endcase
		end
	end

endmodule
